FILE: rtl/core/prs_pkg.sv
// Shared types and constants of the power rail supervisor.
// Holds the register map, supply mode codes, rail windows and fixed thresholds.
// No dependencies.
`default_nettype none

package prs_pkg;

  localparam int RailNum = 7;

  // supply mode codes
  localparam logic [1:0] MODE_NORMAL   = 2'd0;
  localparam logic [1:0] MODE_BROWNOUT = 2'd1;
  localparam logic [1:0] MODE_CRITICAL = 2'd2;

  // fault mask bits
  localparam int F_CAPLOW   = 6;
  localparam int F_BROWNOUT = 7;
  localparam int F_OVERVOLT = 8;
  localparam int F_OVERTEMP = 9;

  // event mask bits
  localparam int E_SHUTDOWN  = 0;
  localparam int E_WARNING   = 1;
  localparam int E_RECOVERED = 2;
  localparam int E_RAIL      = 3;
  localparam int E_OVERTEMP  = 4;
  localparam int E_CAPLOW    = 5;

  localparam logic [15:0] CapLowMv   = 16'd2500;
  localparam logic [15:0] CapEmptyMv = 16'd2000;
  localparam logic [15:0] CapFullMv  = 16'd3800;
  localparam logic [31:0] MsPerS     = 32'd1000;

  // (x * CapPctMul) >> 16 equals x / 18 for x below 1800
  localparam logic [11:0] CapPctMul = 12'd3641;
  // (n * SecMul) >> 38 equals n / 1000 for any 32 bit n
  localparam logic [28:0] SecMul   = 29'h10624DD3;
  localparam int          SecShift = 38;

  localparam logic [15:0] WIN_LO [RailNum] = '{
    16'd20000, 16'd4750, 16'd3135, 16'd3135, 16'd1140, 16'd11400, 16'd2000
  };
  localparam logic [15:0] WIN_HI [RailNum] = '{
    16'd28000, 16'd5250, 16'd3465, 16'd3465, 16'd1260, 16'd12600, 16'd3800
  };

  typedef enum logic [2:0] {
    REG_WARN_THR     = 3'd0,
    REG_SHUTDOWN_THR = 3'd1,
    REG_OVERVOLT_THR = 3'd2,
    REG_TEMP_LIMIT   = 3'd3,
    REG_HOLDOFF      = 3'd4
  } prs_reg_e;

  typedef struct packed {
    logic [15:0]        warn_threshold_mv;
    logic [15:0]        shutdown_threshold_mv;
    logic [15:0]        overvolt_threshold_mv;
    logic signed [7:0]  temp_limit;
    logic [31:0]        holdoff_ms;
  } prs_cfg_t;

endpackage

`default_nettype wire

FILE: rtl/core/prs_apb_regs.sv
// APB configuration registers of the power rail supervisor.
// Depends on prs_pkg for the register map and the configuration struct.
`default_nettype none

module prs_apb_regs
  import prs_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output prs_cfg_t         cfg_o
);

  prs_cfg_t cfg_q;
  prs_reg_e reg_idx;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_idx = prs_reg_e'(paddr[4:2]);
  assign wr_en   = psel && penable && pwrite;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.warn_threshold_mv     <= 16'd21000;
      cfg_q.shutdown_threshold_mv <= 16'd19000;
      cfg_q.overvolt_threshold_mv <= 16'd28500;
      cfg_q.temp_limit            <= 8'sd70;
      cfg_q.holdoff_ms            <= 32'd50;
    end else if (wr_en) begin
      case (reg_idx)
        REG_WARN_THR:     cfg_q.warn_threshold_mv     <= pwdata[15:0];
        REG_SHUTDOWN_THR: cfg_q.shutdown_threshold_mv <= pwdata[15:0];
        REG_OVERVOLT_THR: cfg_q.overvolt_threshold_mv <= pwdata[15:0];
        REG_TEMP_LIMIT:   cfg_q.temp_limit            <= $signed(pwdata[7:0]);
        REG_HOLDOFF:      cfg_q.holdoff_ms            <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WARN_THR:     prdata = {16'd0, cfg_q.warn_threshold_mv};
      REG_SHUTDOWN_THR: prdata = {16'd0, cfg_q.shutdown_threshold_mv};
      REG_OVERVOLT_THR: prdata = {16'd0, cfg_q.overvolt_threshold_mv};
      REG_TEMP_LIMIT:   prdata = {{24{cfg_q.temp_limit[7]}}, cfg_q.temp_limit};
      REG_HOLDOFF:      prdata = cfg_q.holdoff_ms;
      default:          prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/power_rail_supervisor.sv
// Top level of the power rail supervisor: sample register, evaluation stage, mid
// register, uptime stage and result register. Depends on prs_pkg and prs_apb_regs.
//
//   channel  direction  handshake               payload
//   in       sink       in_valid_i / in_stall_o  vin_mv_i .. now_ms_i
//   out      source     out_valid_o / out_stall_i supply_state_o .. uptime_s_o
//   cfg      APB slave  psel/penable/pready      paddr, pwdata, prdata
//
// One request is taken per cycle while in_stall_o is low; each gives one result.
// The supply state machine advances as a request leaves the sample register;
// the uptime counter adds whole seconds (a 32x29 reciprocal multiply) as it
// enters the result register. A stall on out backs up through all three
// registers before in_stall_o rises. Reset clears all but the data registers; no clearing pass.
`default_nettype none

module power_rail_supervisor
  import prs_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // APB configuration
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [4:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  // sample channel
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [15:0]       vin_mv_i,
  input  wire logic [15:0]       five_volt_mv_i,
  input  wire logic [15:0]       digital_3v3_mv_i,
  input  wire logic [15:0]       core_1v2_mv_i,
  input  wire logic [15:0]       sensor_12v_mv_i,
  input  wire logic [15:0]       backup_cap_mv_i,
  input  wire logic signed [7:0] board_temp_i,
  input  wire logic [31:0]       now_ms_i,
  // result channel
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [1:0]             supply_state_o,
  output logic                   on_backup_o,
  output logic [9:0]             fault_mask_o,
  output logic [5:0]             event_mask_o,
  output logic [6:0]             cap_percent_o,
  output logic [31:0]            brownout_total_o,
  output logic [31:0]            uptime_s_o
);

  prs_cfg_t cfg;

  prs_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // ---------------------------------------------------------------- flow
  logic in_valid_q, mid_valid_q, out_valid_q;
  logic in_en, mid_en, out_en;
  logic a_fire, b_fire;

  assign out_en     = !out_valid_q || !out_stall_i;
  assign mid_en     = !mid_valid_q || out_en;
  assign in_en      = !in_valid_q || mid_en;
  assign a_fire     = in_valid_q && mid_en;
  assign b_fire     = mid_valid_q && out_en;
  assign in_stall_o = !in_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      mid_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_en)  in_valid_q  <= in_valid_i;
      if (mid_en) mid_valid_q <= in_valid_q;
      if (out_en) out_valid_q <= mid_valid_q;
    end
  end

  // ------------------------------------------------------ sample register
  logic [15:0]       vin_q, five_q, d3v3_q, core_q, s12_q, cap_q;
  logic signed [7:0] temp_q;
  logic [31:0]       now_q;

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_en) begin
      vin_q  <= vin_mv_i;
      five_q <= five_volt_mv_i;
      d3v3_q <= digital_3v3_mv_i;
      core_q <= core_1v2_mv_i;
      s12_q  <= sensor_12v_mv_i;
      cap_q  <= backup_cap_mv_i;
      temp_q <= board_temp_i;
      now_q  <= now_ms_i;
    end
  end

  // ----------------------------------------------------- evaluation stage
  logic        low_active_q, low_active_d;
  logic [31:0] low_start_q, low_start_d;
  logic [1:0]  mode_q, mode_d;
  logic        backup_q, backup_d;
  logic        brown_q, brown_d;
  logic        otemp_q, otemp_d;
  logic [31:0] episode_q, episode_d;
  logic [31:0] last_tick_q, last_tick_d;
  logic [31:0] elapsed, tick_delta, sec_delta;
  logic        past_holdoff;
  logic [15:0] rail [RailNum];
  logic [RailNum-1:0] rail_bad;
  logic [9:0]  faults;
  logic [5:0]  events;
  logic [10:0] cap_off;
  logic [22:0] pct_prod;
  logic [6:0]  pct;

  assign rail[0] = vin_q;
  assign rail[1] = five_q;
  assign rail[2] = d3v3_q;
  assign rail[3] = d3v3_q;
  assign rail[4] = core_q;
  assign rail[5] = s12_q;
  assign rail[6] = cap_q;

  assign elapsed      = now_q - low_start_q;
  assign past_holdoff = elapsed > cfg.holdoff_ms;

  always_comb begin
    low_active_d = low_active_q;
    low_start_d  = low_start_q;
    mode_d       = mode_q;
    backup_d     = backup_q;
    brown_d      = brown_q;
    episode_d    = episode_q;
    events       = '0;

    if (vin_q < cfg.shutdown_threshold_mv) begin
      if (!low_active_q || past_holdoff) begin
        mode_d               = MODE_CRITICAL;
        backup_d             = 1'b1;
        brown_d              = 1'b1;
        events[E_SHUTDOWN]   = 1'b1;
      end
      if (!low_active_q) begin
        low_active_d = 1'b1;
        low_start_d  = now_q;
        episode_d    = episode_q + 32'd1;
      end
    end else if (vin_q < cfg.warn_threshold_mv) begin
      // a fresh episode starts at zero elapsed time, so it cannot fire yet
      if (!low_active_q) begin
        low_active_d = 1'b1;
        low_start_d  = now_q;
      end else if (past_holdoff) begin
        mode_d            = MODE_BROWNOUT;
        brown_d           = 1'b1;
        events[E_WARNING] = 1'b1;
      end
    end else if (low_active_q) begin
      low_active_d = 1'b0;
      brown_d      = 1'b0;
      if (mode_q inside {MODE_BROWNOUT, MODE_CRITICAL}) begin
        mode_d              = MODE_NORMAL;
        backup_d            = 1'b0;
        events[E_RECOVERED] = 1'b1;
      end
    end

    for (int i = 0; i < RailNum; i++) begin
      rail_bad[i] = (rail[i] < WIN_LO[i]) || (rail[i] > WIN_HI[i]);
    end

    otemp_d = otemp_q || (temp_q > cfg.temp_limit);

    faults              = '0;
    faults[RailNum-1:0] = rail_bad;
    faults[F_BROWNOUT]  = brown_d;
    faults[F_OVERVOLT]  = vin_q > cfg.overvolt_threshold_mv;
    faults[F_OVERTEMP]  = otemp_d;
    if (cap_q < CapLowMv) faults[F_CAPLOW] = 1'b1;

    events[E_RAIL]     = |rail_bad[5:0];
    events[E_OVERTEMP] = temp_q > cfg.temp_limit;
    events[E_CAPLOW]   = cap_q < CapLowMv;
  end

  // supercap percent: offset above empty, divided by 18 via reciprocal
  assign cap_off  = cap_q[10:0] - CapEmptyMv[10:0];
  assign pct_prod = {12'd0, cap_off} * {11'd0, CapPctMul};

  always_comb begin
    if (cap_q <= CapEmptyMv) begin
      pct = 7'd0;
    end else if (cap_q >= CapFullMv) begin
      pct = 7'd100;
    end else begin
      pct = pct_prod[22:16];
    end
  end

  // uptime tick: pass the whole elapsed span on, drop the remainder
  assign tick_delta = now_q - last_tick_q;

  always_comb begin
    if (tick_delta >= MsPerS) begin
      last_tick_d = now_q;
      sec_delta   = tick_delta;
    end else begin
      last_tick_d = last_tick_q;
      sec_delta   = 32'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_active_q <= 1'b0;
      low_start_q  <= 32'd0;
      mode_q       <= MODE_NORMAL;
      backup_q     <= 1'b0;
      brown_q      <= 1'b0;
      otemp_q      <= 1'b0;
      episode_q    <= 32'd0;
      last_tick_q  <= 32'd0;
    end else if (a_fire) begin
      low_active_q <= low_active_d;
      low_start_q  <= low_start_d;
      mode_q       <= mode_d;
      backup_q     <= backup_d;
      brown_q      <= brown_d;
      otemp_q      <= otemp_d;
      episode_q    <= episode_d;
      last_tick_q  <= last_tick_d;
    end
  end

  // --------------------------------------------------------- mid register
  logic [1:0]  mid_mode_q;
  logic        mid_backup_q;
  logic [9:0]  mid_faults_q;
  logic [5:0]  mid_events_q;
  logic [6:0]  mid_pct_q;
  logic [31:0] mid_episode_q;
  logic [31:0] mid_delta_q;

  always_ff @(posedge clk_i) begin
    if (a_fire) begin
      mid_mode_q    <= mode_d;
      mid_backup_q  <= backup_d;
      mid_faults_q  <= faults;
      mid_events_q  <= events;
      mid_pct_q     <= pct;
      mid_episode_q <= episode_d;
      mid_delta_q   <= sec_delta;
    end
  end

  // --------------------------------------------------------- uptime stage
  logic [60:0] sec_prod;
  logic [31:0] sec_add;
  logic [31:0] seconds_up_q;

  assign sec_prod = {29'd0, mid_delta_q} * {32'd0, SecMul};
  assign sec_add  = {9'd0, sec_prod[60:SecShift]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seconds_up_q <= 32'd0;
    end else if (b_fire) begin
      seconds_up_q <= seconds_up_q + sec_add;
    end
  end

  // ------------------------------------------------------ result register
  always_ff @(posedge clk_i) begin
    if (b_fire) begin
      supply_state_o   <= mid_mode_q;
      on_backup_o      <= mid_backup_q;
      fault_mask_o     <= mid_faults_q;
      event_mask_o     <= mid_events_q;
      cap_percent_o    <= mid_pct_q;
      brownout_total_o <= mid_episode_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign uptime_s_o  = seconds_up_q;

  // ------------------------------------------------------------ checks
  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> !in_stall_o)
    else $error("sample register empty yet input stalled");

  a_critical_on_backup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_CRITICAL |-> backup_q)
    else $error("critical mode without backup source");

  a_mode_needs_episode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q != MODE_NORMAL || brown_q) |-> low_active_q)
    else $error("brownout state held outside a low input episode");

  a_uptime_only_on_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !b_fire |=> $stable(seconds_up_q))
    else $error("uptime changed without a result advancing");

endmodule

`default_nettype wire

FILE: test/power_rail_supervisor_checker.sv
// Checker of the power rail supervisor: watches the config port and both channels,
// predicts every status from the accepted polls and compares it field by field.
// Depends on prs_pkg.
module power_rail_supervisor_checker
  import prs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic               pready_i,
  input  logic [4:0]         paddr_i,
  input  logic [31:0]        pwdata_i,
  input  logic               poll_valid_i,
  input  logic               poll_stall_i,
  input  logic [15:0]        vin_mv_i,
  input  logic [15:0]        five_volt_mv_i,
  input  logic [15:0]        digital_3v3_mv_i,
  input  logic [15:0]        core_1v2_mv_i,
  input  logic [15:0]        sensor_12v_mv_i,
  input  logic [15:0]        backup_cap_mv_i,
  input  logic signed [7:0]  board_temp_i,
  input  logic [31:0]        now_ms_i,
  input  logic               status_valid_i,
  input  logic               status_stall_i,
  input  logic [1:0]         supply_state_i,
  input  logic               on_backup_i,
  input  logic [9:0]         fault_mask_i,
  input  logic [5:0]         event_mask_i,
  input  logic [6:0]         cap_percent_i,
  input  logic [31:0]        brownout_total_i,
  input  logic [31:0]        uptime_s_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 checked_o,
  output int                 shutdowns_o,
  output int                 warnings_o,
  output int                 recoveries_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0]       vin;
    logic [15:0]       five;
    logic [15:0]       d3v3;
    logic [15:0]       core;
    logic [15:0]       s12v;
    logic [15:0]       cap;
    logic signed [7:0] temp;
    logic [31:0]       now;
  } poll_t;

  typedef struct packed {
    logic [1:0]  state;
    logic        backup;
    logic [9:0]  faults;
    logic [5:0]  events;
    logic [6:0]  pct;
    logic [31:0] brownouts;
    logic [31:0] uptime;
  } status_t;

  localparam int          CAP_RAIL     = 6;
  localparam int unsigned CAP_EMPTY_MV = 2000;
  localparam int unsigned CAP_FULL_MV  = 3800;
  localparam int unsigned CAP_SPAN_MV  = 1800;
  localparam int unsigned CAP_LOW_MV   = 2500;
  localparam int unsigned MS_PER_S     = 1000;
  localparam logic [15:0] RAIL_FLOOR_MV [RailNum] = '{
    16'd20000, 16'd4750, 16'd3135, 16'd3135, 16'd1140, 16'd11400, 16'd2000
  };
  localparam logic [15:0] RAIL_CEIL_MV [RailNum] = '{
    16'd28000, 16'd5250, 16'd3465, 16'd3465, 16'd1260, 16'd12600, 16'd3800
  };
  localparam logic [9:0] STICKY_FAULTS = (10'd1 << F_BROWNOUT) | (10'd1 << F_OVERTEMP);

  // limits as last written over the config port
  logic [15:0]       warn_mv;
  logic [15:0]       shut_mv;
  logic [15:0]       over_mv;
  logic signed [7:0] temp_lim;
  logic [31:0]       holdoff;

  // supervisor state
  logic        low_active;
  logic [31:0] low_start;
  logic [1:0]  mode;
  logic        on_cap;
  logic [9:0]  faults;
  logic [31:0] episodes;
  logic [31:0] seconds;
  logic [31:0] last_tick;

  status_t status_due_q [$];
  poll_t   sample;
  status_t predicted;
  status_t observed;
  status_t oldest;

  int mismatches = 0;
  int pending    = 0;
  int checked    = 0;
  int shutdowns  = 0;
  int warnings   = 0;
  int recoveries = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = pending;
  assign checked_o    = checked;
  assign shutdowns_o  = shutdowns;
  assign warnings_o   = warnings;
  assign recoveries_o = recoveries;

  task automatic step_supervisor(input poll_t s, output status_t r);
    logic [15:0] rail [RailNum];
    logic [5:0]  ev;
    logic [31:0] elapsed;
    int unsigned pct;
    ev      = '0;
    rail[0] = s.vin;
    rail[1] = s.five;
    rail[2] = s.d3v3;
    rail[3] = s.d3v3;
    rail[4] = s.core;
    rail[5] = s.s12v;
    rail[6] = s.cap;

    if (s.cap <= CAP_EMPTY_MV) pct = 0;
    else if (s.cap >= CAP_FULL_MV) pct = 100;
    else pct = (32'(s.cap) - CAP_EMPTY_MV) * 100 / CAP_SPAN_MV;

    elapsed = s.now - low_start;
    if (s.vin < shut_mv) begin
      if (!low_active || elapsed > holdoff) begin
        mode               = MODE_CRITICAL;
        on_cap             = 1'b1;
        faults[F_BROWNOUT] = 1'b1;
        ev[E_SHUTDOWN]     = 1'b1;
      end
      // count an episode only when it opens on the critical path
      if (!low_active) begin
        low_active = 1'b1;
        low_start  = s.now;
        episodes   = episodes + 32'd1;
      end
    end else if (s.vin < warn_mv) begin
      if (!low_active) begin
        low_active = 1'b1;
        low_start  = s.now;
      end
      elapsed = s.now - low_start;
      if (elapsed > holdoff) begin
        mode               = MODE_BROWNOUT;
        faults[F_BROWNOUT] = 1'b1;
        ev[E_WARNING]      = 1'b1;
      end
    end else if (low_active) begin
      low_active         = 1'b0;
      faults[F_BROWNOUT] = 1'b0;
      if (mode == MODE_BROWNOUT || mode == MODE_CRITICAL) begin
        mode            = MODE_NORMAL;
        on_cap          = 1'b0;
        ev[E_RECOVERED] = 1'b1;
      end
    end

    faults = faults & STICKY_FAULTS;
    for (int i = 0; i < RailNum; i++) begin
      if (rail[i] < RAIL_FLOOR_MV[i] || rail[i] > RAIL_CEIL_MV[i]) begin
        faults[i] = 1'b1;
        if (i != CAP_RAIL) ev[E_RAIL] = 1'b1;
      end
    end
    if (s.vin > over_mv) faults[F_OVERVOLT] = 1'b1;
    if ($signed(s.temp) > temp_lim) begin
      faults[F_OVERTEMP] = 1'b1;
      ev[E_OVERTEMP]     = 1'b1;
    end
    if (s.cap < CAP_LOW_MV) begin
      faults[F_CAPLOW] = 1'b1;
      ev[E_CAPLOW]     = 1'b1;
    end

    // add whole seconds only, drop the remainder
    elapsed = s.now - last_tick;
    if (elapsed >= MS_PER_S) begin
      seconds   = seconds + elapsed / MS_PER_S;
      last_tick = s.now;
    end

    r.state     = mode;
    r.backup    = on_cap;
    r.faults    = faults;
    r.events    = ev;
    r.pct       = 7'(pct);
    r.brownouts = episodes;
    r.uptime    = seconds;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s wrong on status %0d: expected %0h, got %0h",
                 $realtime, name, checked, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warn_mv    = 16'd21000;
      shut_mv    = 16'd19000;
      over_mv    = 16'd28500;
      temp_lim   = 8'sd70;
      holdoff    = 32'd50;
      low_active = 1'b0;
      low_start  = '0;
      mode       = MODE_NORMAL;
      on_cap     = 1'b0;
      faults     = '0;
      episodes   = '0;
      seconds    = '0;
      last_tick  = '0;
      status_due_q.delete();
      pending    = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (prs_reg_e'(paddr_i[4:2]))
          REG_WARN_THR:     warn_mv  = pwdata_i[15:0];
          REG_SHUTDOWN_THR: shut_mv  = pwdata_i[15:0];
          REG_OVERVOLT_THR: over_mv  = pwdata_i[15:0];
          REG_TEMP_LIMIT:   temp_lim = pwdata_i[7:0];
          REG_HOLDOFF:      holdoff  = pwdata_i;
          default: ;
        endcase
      end

      // retire the oldest status before predicting a new one
      if (status_valid_i && !status_stall_i) begin
        observed = {supply_state_i, on_backup_i, fault_mask_i, event_mask_i,
                    cap_percent_i, brownout_total_i, uptime_s_i};
        if (status_due_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: status with no poll outstanding: %0h", $realtime, observed);
        end else begin
          oldest = status_due_q.pop_front();
          pending--;
          check_field("supply_state", oldest.state, observed.state);
          check_field("on_backup", oldest.backup, observed.backup);
          check_field("fault_mask", oldest.faults, observed.faults);
          check_field("event_mask", oldest.events, observed.events);
          check_field("cap_percent", oldest.pct, observed.pct);
          check_field("brownout_total", oldest.brownouts, observed.brownouts);
          check_field("uptime_s", oldest.uptime, observed.uptime);
          checked++;
        end
      end

      if (poll_valid_i && !poll_stall_i) begin
        sample = {vin_mv_i, five_volt_mv_i, digital_3v3_mv_i, core_1v2_mv_i,
                  sensor_12v_mv_i, backup_cap_mv_i, board_temp_i, now_ms_i};
        step_supervisor(sample, predicted);
        status_due_q.push_back(predicted);
        pending++;
        if (predicted.events[E_SHUTDOWN]) shutdowns++;
        if (predicted.events[E_WARNING]) warnings++;
        if (predicted.events[E_RECOVERED]) recoveries++;
      end
    end
  end

endmodule

FILE: test/power_rail_supervisor_tb.sv
// Testbench top of the power rail supervisor: clock, reset, limit writes and poll stimulus.
// Depends on prs_pkg, power_rail_supervisor and power_rail_supervisor_checker.
module power_rail_supervisor_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import prs_pkg::*;

  typedef struct packed {
    logic [15:0]       vin;
    logic [15:0]       five;
    logic [15:0]       d3v3;
    logic [15:0]       core;
    logic [15:0]       s12v;
    logic [15:0]       cap;
    logic signed [7:0] temp;
    logic [31:0]       now;
  } poll_t;

  typedef enum int {BAND_NORMAL, BAND_WARN, BAND_CRIT, BAND_OVER, BAND_NOISE} vin_band_e;

  localparam int PHASES      = 8;
  localparam int PHASE_POLLS = 175;

  logic              clk_i            = 1'b0;
  logic              rst_ni           = 1'b0;
  logic              psel             = 1'b0;
  logic              penable          = 1'b0;
  logic              pwrite           = 1'b0;
  logic [4:0]        paddr            = '0;
  logic [31:0]       pwdata           = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid_i       = 1'b0;
  logic              in_stall_o;
  logic [15:0]       vin_mv_i         = '0;
  logic [15:0]       five_volt_mv_i   = '0;
  logic [15:0]       digital_3v3_mv_i = '0;
  logic [15:0]       core_1v2_mv_i    = '0;
  logic [15:0]       sensor_12v_mv_i  = '0;
  logic [15:0]       backup_cap_mv_i  = '0;
  logic signed [7:0] board_temp_i     = '0;
  logic [31:0]       now_ms_i         = '0;
  logic              out_valid_o;
  logic              out_stall_i      = 1'b0;
  logic [1:0]        supply_state_o;
  logic              on_backup_o;
  logic [9:0]        fault_mask_o;
  logic [5:0]        event_mask_o;
  logic [6:0]        cap_percent_o;
  logic [31:0]       brownout_total_o;
  logic [31:0]       uptime_s_o;

  int fail_count;
  int pending;
  int checked;
  int shutdowns;
  int warnings;
  int recoveries;
  int sent = 0;
  int settings_used = 1;

  // limits as written, used to shape the input trajectories
  logic [15:0]       warn_mv  = 16'd21000;
  logic [15:0]       shut_mv  = 16'd19000;
  logic [15:0]       over_mv  = 16'd28500;
  logic signed [7:0] temp_lim = 8'sd70;
  logic [31:0]       holdoff  = 32'd50;

  bit in_calm  = 1'b0;
  bit out_calm = 1'b0;

  power_rail_supervisor dut (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_stall_o,
    .vin_mv_i, .five_volt_mv_i, .digital_3v3_mv_i, .core_1v2_mv_i,
    .sensor_12v_mv_i, .backup_cap_mv_i, .board_temp_i, .now_ms_i,
    .out_valid_o, .out_stall_i,
    .supply_state_o, .on_backup_o, .fault_mask_o, .event_mask_o,
    .cap_percent_o, .brownout_total_o, .uptime_s_o
  );

  power_rail_supervisor_checker checker_i (
    .clk_i, .rst_ni,
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .pready_i(pready),
    .paddr_i(paddr), .pwdata_i(pwdata),
    .poll_valid_i(in_valid_i), .poll_stall_i(in_stall_o),
    .vin_mv_i, .five_volt_mv_i, .digital_3v3_mv_i, .core_1v2_mv_i,
    .sensor_12v_mv_i, .backup_cap_mv_i, .board_temp_i, .now_ms_i,
    .status_valid_i(out_valid_o), .status_stall_i(out_stall_i),
    .supply_state_i(supply_state_o), .on_backup_i(on_backup_o),
    .fault_mask_i(fault_mask_o), .event_mask_i(event_mask_o),
    .cap_percent_i(cap_percent_o), .brownout_total_i(brownout_total_o),
    .uptime_s_i(uptime_s_o),
    .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked),
    .shutdowns_o(shutdowns), .warnings_o(warnings), .recoveries_o(recoveries)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // watchdog: the worst case of the whole run of polls stays far below this limit
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int pick_wait();
    int draw;
    draw = $urandom_range(0, 9);
    if (draw < 5) return 0;
    if (draw < 8) return $urandom_range(1, 3);
    return $urandom_range(0, 18);
  endfunction

  function automatic logic [15:0] pick_between(input int lo, input int hi);
    if (lo > hi) return 16'($urandom);
    return 16'($urandom_range(hi, lo));
  endfunction

  function automatic logic [15:0] rail_value(input logic [15:0] lo, input logic [15:0] hi);
    int draw;
    draw = $urandom_range(0, 19);
    if (draw < 16) return 16'($urandom_range(hi, lo));
    if (draw == 16) return lo - 16'd1;
    if (draw == 17) return hi + 16'd1;
    return 16'($urandom);
  endfunction

  function automatic poll_t nominal_poll(input logic [31:0] t);
    poll_t p;
    p.vin  = 16'd24000;
    p.five = 16'd5000;
    p.d3v3 = 16'd3300;
    p.core = 16'd1200;
    p.s12v = 16'd12000;
    p.cap  = 16'd3600;
    p.temp = 8'sd25;
    p.now  = t;
    return p;
  endfunction

  task automatic apb_write(input prs_reg_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_sample(input poll_t p);
    int gap;
    if ($urandom_range(0, 40) == 0) in_calm = !in_calm;
    gap = in_calm ? 0 : pick_wait();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    vin_mv_i         <= p.vin;
    five_volt_mv_i   <= p.five;
    digital_3v3_mv_i <= p.d3v3;
    core_1v2_mv_i    <= p.core;
    sensor_12v_mv_i  <= p.s12v;
    backup_cap_mv_i  <= p.cap;
    board_temp_i     <= p.temp;
    now_ms_i         <= p.now;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent++;
  endtask

  // result side: stall for a drawn number of cycles, then take one status
  initial begin : status_sink
    int hold_cycles;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 40) == 0) out_calm = !out_calm;
      hold_cycles = out_calm ? 0 : pick_wait();
      if (hold_cycles > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold_cycles) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  initial begin : stimulus
    poll_t     p;
    vin_band_e band;
    int        band_left;
    int        draw;
    int        tv;
    int        directed;
    band      = BAND_NORMAL;
    band_left = 0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // warning path: open an episode, end it early, then cross the holdoff strictly
    send_sample(nominal_poll(32'd0));
    p = nominal_poll(32'd10);  p.vin = 16'd20500; send_sample(p);
    send_sample(nominal_poll(32'd20));
    p = nominal_poll(32'd100); p.vin = 16'd20500; send_sample(p);
    p.now = 32'd150; send_sample(p);
    p.now = 32'd151; send_sample(p);
    send_sample(nominal_poll(32'd160));
    // critical path from an all-zero poll, re-entry inside and past the holdoff
    p = '0; p.temp = -8'sd128; p.now = 32'd200; send_sample(p);
    p = nominal_poll(32'd240); p.vin = 16'd18999; send_sample(p);
    p.vin = 16'd20500; p.now = 32'd300; send_sample(p);
    p.vin = 16'd18000; p.now = 32'd310; send_sample(p);
    p.vin = 16'd19000; p.now = 32'd320; send_sample(p);
    p.vin = 16'd21000; p.now = 32'd330; send_sample(p);
    // all fields at their top, overtemperature stays set from here on
    p = '1; p.temp = 8'sd127; p.now = 32'd1999; send_sample(p);
    p = nominal_poll(32'd2998); p.temp = 8'sd70; send_sample(p);
    p.temp = 8'sd71; p.now = 32'd2999; send_sample(p);
    // window edges, inside then just outside
    p = '{16'd28000, 16'd4750, 16'd3135, 16'd1140, 16'd11400, 16'd2000, 8'sd0, 32'd3000};
    send_sample(p);
    p = '{16'd28500, 16'd5250, 16'd3465, 16'd1260, 16'd12600, 16'd3800, 8'sd0, 32'd3010};
    send_sample(p);
    p = '{16'd28501, 16'd5251, 16'd3466, 16'd1261, 16'd12601, 16'd3801, 8'sd0, 32'd3020};
    send_sample(p);
    p = nominal_poll(32'd3030); p.cap = 16'd3801; send_sample(p);
    p = '{16'd24000, 16'd4749, 16'd3134, 16'd1139, 16'd11399, 16'd1999, 8'sd0, 32'd3040};
    send_sample(p);
    p = nominal_poll(32'd3050); p.cap = 16'd2500; send_sample(p);
    p.cap = 16'd2499; p.now = 32'd3060; send_sample(p);
    p.cap = 16'd3799; p.now = 32'd3070; send_sample(p);
    // tick wrap: large jump, short step across zero, then one more second
    send_sample(nominal_poll(32'hFFFF_FF00));
    send_sample(nominal_poll(32'h0000_0200));
    send_sample(nominal_poll(32'h0000_0300));
    directed = sent;

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
        repeat (4) @(posedge clk_i);
        case (ph)
          1: begin
            warn_mv  = '0;
            shut_mv  = '0;
            over_mv  = '0;
            temp_lim = -8'sd128;
            holdoff  = '0;
          end
          2: begin
            warn_mv  = '1;
            shut_mv  = '1;
            over_mv  = '1;
            temp_lim = 8'sd127;
            holdoff  = '1;
          end
          default: begin
            warn_mv  = 16'($urandom_range(23000, 19500));
            shut_mv  = 16'($urandom_range(21000, 15000));
            over_mv  = 16'($urandom_range(30000, 25000));
            tv       = int'($urandom_range(0, 100)) - 20;
            temp_lim = tv[7:0];
            holdoff  = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 5))
                                                   : 32'($urandom_range(20, 150));
          end
        endcase
        apb_write(REG_WARN_THR, {16'h0, warn_mv});
        apb_write(REG_SHUTDOWN_THR, {16'h0, shut_mv});
        apb_write(REG_OVERVOLT_THR, {16'h0, over_mv});
        apb_write(REG_TEMP_LIMIT, {{24{temp_lim[7]}}, temp_lim});
        apb_write(REG_HOLDOFF, holdoff);
        settings_used++;
      end

      for (int k = 0; k < PHASE_POLLS; k++) begin
        // hold the input rail in one band for a run of polls
        if (band_left == 0) begin
          draw = $urandom_range(0, 99);
          if (draw < 35) band = BAND_NORMAL;
          else if (draw < 60) band = BAND_WARN;
          else if (draw < 80) band = BAND_CRIT;
          else if (draw < 85) band = BAND_OVER;
          else band = BAND_NOISE;
          band_left = $urandom_range(1, 12);
        end
        band_left--;
        case (band)
          BAND_NORMAL: p.vin = pick_between(int'(warn_mv), int'(over_mv));
          BAND_WARN:   p.vin = pick_between(int'(shut_mv), int'(warn_mv) - 1);
          BAND_CRIT:   p.vin = pick_between(0, int'(shut_mv) - 1);
          BAND_OVER:   p.vin = pick_between(int'(over_mv) + 1, 65535);
          default:     p.vin = 16'($urandom);
        endcase
        p.five = rail_value(WIN_LO[1], WIN_HI[1]);
        p.d3v3 = rail_value(WIN_LO[2], WIN_HI[2]);
        p.core = rail_value(WIN_LO[4], WIN_HI[4]);
        p.s12v = rail_value(WIN_LO[5], WIN_HI[5]);
        p.cap  = rail_value(WIN_LO[6], WIN_HI[6]);
        if ($urandom_range(0, 3) == 0) begin
          p.temp = 8'($urandom);
        end else begin
          tv = int'(temp_lim) + int'($urandom_range(0, 14)) - 10;
          if (tv > 127) tv = 127;
          if (tv < -128) tv = -128;
          p.temp = tv[7:0];
        end
        draw = $urandom_range(0, 99);
        if (draw < 70) p.now = p.now + $urandom_range(0, 40);
        else if (draw < 90) p.now = p.now + $urandom_range(0, 3000);
        else if (draw < 98) p.now = p.now + $urandom_range(0, 200000);
        else p.now = $urandom;
        send_sample(p);
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    $display("Checked %0d statuses from %0d polls (%0d directed) over %0d limit settings.",
             checked, sent, directed, settings_used);
    $display("Predicted events: %0d shutdown, %0d warning, %0d recovery.",
             shutdowns, warnings, recoveries);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/prs_pkg.sv
rtl/core/prs_apb_regs.sv
rtl/core/power_rail_supervisor.sv
test/power_rail_supervisor_checker.sv
test/power_rail_supervisor_tb.sv
